// ----- design/tpx_pkg.sv -----
// Shared types, constants and helpers for the ToF phase to XYZ converter.
package tpx_pkg;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_PIX = 2'd0,
        KIND_Z   = 2'd1,
        KIND_Y   = 2'd2,
        KIND_X   = 2'd3
    } kind_t;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] IDX_FRAME_COLS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_FRAME_ROWS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_CENTRE_COL = 4'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_CENTRE_ROW = 4'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_PITCH_COL  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_PITCH_ROW  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_FOCAL_LEN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_MAX_RANGE  = 4'd7;

    // Datapath widths
    localparam int SIZE_W    = 13;  // clamped frame size, up to 2047
    localparam int MAG_W     = 16;  // sensor offset magnitude in pixels Q.4
    localparam int NORM_BITS = 26;  // ray components are brought below 2^26
    localparam int PROD_W    = 40;  // offset magnitude times pitch
    localparam int ROOT_W    = 27;  // ray length
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 26;
    localparam int NUM_W     = MUL_A_W + MUL_B_W;
    localparam int DEN_W     = ROOT_W + 16;
    localparam int QUOT_W    = 16;
    localparam int VAL_W     = 17;

    localparam logic signed [VAL_W-1:0] Z_MIN_START = 17'sd7500;

    typedef struct packed {
        logic [10:0] frame_cols;
        logic [10:0] frame_rows;
        logic [13:0] centre_col;
        logic [13:0] centre_row;
        logic [23:0] pitch_col;
        logic [23:0] pitch_row;
        logic [23:0] focal_len;
        logic [15:0] max_range_mm;
    } cfg_t;

    // One classified pixel request between front and back
    typedef struct packed {
        logic [15:0]      phase;
        logic             xneg;
        logic [MAG_W-1:0] xmag;
        logic             yneg;
        logic [MAG_W-1:0] ymag;
        logic             frame_end;
    } pix_req_t;

    // Frame size: zero counts as one, oversize counts as the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(logic [10:0] v, logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] ve;
        ve = SIZE_W'(v);
        if (v == 11'd0) begin
            return SIZE_W'(1);
        end
        return (ve > maxv) ? maxv : ve;
    endfunction

endpackage

// ----- design/tpx_front.sv -----
// Front end: raster counters, frame end detection and centre offsets per pixel.
module tpx_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tpx_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_phase,
    input  logic              q_full,
    output logic              q_push,
    output tpx_pkg::pix_req_t q_data
);
    import tpx_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SIZE_W-1:0] ec, er;
    logic col_wrap, row_wrap;
    logic signed [17:0] dc, dr;
    logic [17:0] dc_mag, dr_mag;

    assign ec = clamp_size(cfg.frame_cols, SIZE_W'(MAX_COLS));
    assign er = clamp_size(cfg.frame_rows, SIZE_W'(MAX_ROWS));

    assign col_wrap = (SIZE_W'(col_reg) + SIZE_W'(1)) >= ec;
    assign row_wrap = (SIZE_W'(row_reg) + SIZE_W'(1)) >= er;

    // Offsets from the optical centre in Q.4 pixels
    assign dc = $signed({4'b0, cfg.centre_col}) - $signed({14'(col_reg), 4'b0});
    assign dr = $signed({4'b0, cfg.centre_row}) - $signed({14'(row_reg), 4'b0});
    assign dc_mag = dc[17] ? 18'(-dc) : 18'(dc);
    assign dr_mag = dr[17] ? 18'(-dr) : 18'(dr);

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_data.phase     = s_phase;
        q_data.xneg      = dc[17];
        q_data.xmag      = dc_mag[MAG_W-1:0];
        q_data.yneg      = dr[17];
        q_data.ymag      = dr_mag[MAG_W-1:0];
        q_data.frame_end = col_wrap && row_wrap;
    end

    // Raster position advance
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : RW'(row_reg + RW'(1));
        end else begin
            col_next = CW'(col_reg + CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- design/tpx_fifo.sv -----
// Two-entry request queue between the front end and the back end.
module tpx_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tpx_pkg::pix_req_t push_data,
    output logic              full,
    input  logic              pop,
    output tpx_pkg::pix_req_t pop_data,
    output logic              not_empty
);
    import tpx_pkg::*;

    pix_req_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ----- design/tpx_div.sv -----
// Restoring divider, one quotient bit per cycle: a 16-bit quotient or a full-width one.
module tpx_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       wide,
    input  logic [tpx_pkg::NUM_W-1:0]  num,
    input  logic [tpx_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [tpx_pkg::VAL_W-1:0]  quot
);
    import tpx_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(NUM_W);

    logic [REM_W-1:0] rem_reg, trial;
    logic [NUM_W-1:0] sh_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic             ge;

    // Shift in the next numerator bit and compare
    assign trial = {rem_reg[REM_W-2:0], sh_reg[NUM_W-1]};
    assign ge    = trial >= REM_W'(den_reg);
    assign done  = done_reg;
    assign quot  = sh_reg[VAL_W-1:0];

    // Datapath; the narrow mode starts with the upper numerator bits, known below den
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            if (wide) begin
                rem_reg <= '0;
                sh_reg  <= num;
            end else begin
                rem_reg <= REM_W'(num >> QUOT_W);
                sh_reg  <= num << (NUM_W - QUOT_W);
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? REM_W'(trial - REM_W'(den_reg)) : trial;
            sh_reg  <= {sh_reg[NUM_W-2:0], ge};
        end
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= wide ? CNT_W'(NUM_W - 1) : CNT_W'(QUOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/tpx_back.sv -----
// Back end: ray normalization, square root, coordinate divides, frame stats, output.
module tpx_back #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tpx_pkg::cfg_t                    cfg,
    input  logic                             req_valid,
    input  tpx_pkg::pix_req_t                req_data,
    output logic                             req_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_item_kind,
    output logic signed [tpx_pkg::VAL_W-1:0] m_value_a,
    output logic signed [tpx_pkg::VAL_W-1:0] m_value_b,
    output logic signed [tpx_pkg::VAL_W-1:0] m_value_c,
    output logic                             m_last_of_run
);
    import tpx_pkg::*;

    localparam int NW     = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam int SUM_W  = NW + VAL_W + 1;
    localparam int REM_W  = ROOT_W + 3;
    localparam int SCNT_W = $clog2(ROOT_W);

    localparam logic [1:0] AX_Z = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_X = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DNUM, ST_XM, ST_YM, ST_LDY, ST_NORM,
        ST_SQF, ST_SQX, ST_SQY, ST_SQSUM, ST_ROOT, ST_DEN,
        ST_NUM, ST_DSTART, ST_DWAIT, ST_PIX,
        ST_ASTART, ST_AWAIT, ST_AEMIT
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat16(logic neg, logic [QUOT_W-1:0] mag);
        if (neg) begin
            return (mag > 16'd32768) ? -17'sd32768 : -$signed({1'b0, mag});
        end
        return (mag > 16'd32767) ? 17'sd32767 : $signed({1'b0, mag});
    endfunction

    state_t state_reg;
    logic [1:0]        ax_reg;
    logic [SCNT_W-1:0] scnt_reg;

    // Output register
    logic                    out_valid_reg;
    kind_t                   kind_reg;
    logic signed [VAL_W-1:0] a_reg, b_reg, c_reg;
    logic                    last_reg;
    logic                    out_free;

    // Frame statistics
    logic signed [SUM_W-1:0] sum_z_reg, sum_y_reg, sum_x_reg;
    logic signed [VAL_W-1:0] lo_z_reg, hi_z_reg, lo_y_reg, hi_y_reg, lo_x_reg, hi_x_reg;

    // Datapath registers
    pix_req_t              req_reg;
    logic [NUM_W-1:0]      mul_reg;
    logic [31:0]           dnum_reg;
    logic [PROD_W-1:0]     fm_reg, xm_reg, ym_reg;
    logic [SQ_W-1:0]       acc_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [QUOT_W-1:0]     qz_reg, qy_reg, qx_reg;
    logic signed [VAL_W-1:0] avg_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_B_W-1:0] comp_sel;
    logic [PROD_W-1:0]  norm_or;
    logic               norm_more;
    logic [REM_W-1:0]   rem_n, trial;
    logic               root_ge;
    logic               div_start, div_done, div_wide;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [VAL_W-1:0]   div_quot;
    logic [SIZE_W-1:0]  ec, er;
    logic [2*SIZE_W-1:0] npix;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]   sum_mag;
    logic               sum_neg;
    logic signed [VAL_W-1:0] z_pix, y_pix, x_pix;
    logic signed [VAL_W-1:0] lo_sel, hi_sel;
    kind_t              stat_kind;

    assign req_pop  = (state_reg == ST_IDLE) && req_valid;
    assign out_free = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_item_kind   = kind_reg;
    assign m_value_a     = a_reg;
    assign m_value_b     = b_reg;
    assign m_value_c     = c_reg;
    assign m_last_of_run = last_reg;

    // Component for the current coordinate divide
    always_comb begin
        case (ax_reg)
            AX_Y:    comp_sel = ym_reg[MUL_B_W-1:0];
            AX_X:    comp_sel = xm_reg[MUL_B_W-1:0];
            default: comp_sel = fm_reg[MUL_B_W-1:0];
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DNUM: begin
                mul_a = MUL_A_W'(req_reg.phase);
                mul_b = MUL_B_W'(cfg.max_range_mm);
            end
            ST_XM: begin
                mul_a = MUL_A_W'(cfg.pitch_col);
                mul_b = MUL_B_W'(req_reg.xmag);
            end
            ST_YM: begin
                mul_a = MUL_A_W'(cfg.pitch_row);
                mul_b = MUL_B_W'(req_reg.ymag);
            end
            ST_SQF: begin
                mul_a = MUL_A_W'(fm_reg[MUL_B_W-1:0]);
                mul_b = fm_reg[MUL_B_W-1:0];
            end
            ST_SQX: begin
                mul_a = MUL_A_W'(xm_reg[MUL_B_W-1:0]);
                mul_b = xm_reg[MUL_B_W-1:0];
            end
            ST_SQY: begin
                mul_a = MUL_A_W'(ym_reg[MUL_B_W-1:0]);
                mul_b = ym_reg[MUL_B_W-1:0];
            end
            ST_NUM: begin
                mul_a = dnum_reg;
                mul_b = comp_sel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Normalization and square root step
    assign norm_or   = fm_reg | xm_reg | ym_reg;
    assign norm_more = |norm_or[PROD_W-1:NORM_BITS];
    assign rem_n     = {rem_reg[REM_W-3:0], acc_reg[SQ_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign root_ge   = rem_n >= trial;

    // Pixel values from quotients
    assign z_pix = $signed({1'b0, qz_reg});
    assign y_pix = sat16(req_reg.yneg, qy_reg);
    assign x_pix = sat16(req_reg.xneg, qx_reg);

    // Statistics select for the current axis
    always_comb begin
        case (ax_reg)
            AX_Y: begin
                sum_sel = sum_y_reg; lo_sel = lo_y_reg; hi_sel = hi_y_reg; stat_kind = KIND_Y;
            end
            AX_X: begin
                sum_sel = sum_x_reg; lo_sel = lo_x_reg; hi_sel = hi_x_reg; stat_kind = KIND_X;
            end
            default: begin
                sum_sel = sum_z_reg; lo_sel = lo_z_reg; hi_sel = hi_z_reg; stat_kind = KIND_Z;
            end
        endcase
    end
    assign sum_neg = sum_sel[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

    assign ec   = clamp_size(cfg.frame_cols, SIZE_W'(MAX_COLS));
    assign er   = clamp_size(cfg.frame_rows, SIZE_W'(MAX_ROWS));
    assign npix = ec * er;

    // Divider shared by coordinates and averages; averages take the full quotient
    assign div_start = (state_reg == ST_DSTART) || (state_reg == ST_ASTART);
    assign div_wide  = (state_reg == ST_ASTART);
    assign div_num   = (state_reg == ST_DSTART) ? mul_reg : NUM_W'(sum_mag);
    assign div_den   = (state_reg == ST_DSTART) ? den_reg : DEN_W'(npix);

    tpx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .wide    (div_wide),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Datapath registers
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_reg <= req_data;
                end
            end
            ST_XM: dnum_reg <= mul_reg[31:0];
            ST_YM: xm_reg <= mul_reg[PROD_W-1:0];
            ST_LDY: begin
                ym_reg <= mul_reg[PROD_W-1:0];
                fm_reg <= PROD_W'({cfg.focal_len, 4'b0});
            end
            ST_NORM: begin
                if (norm_more) begin
                    fm_reg <= fm_reg >> 1;
                    xm_reg <= xm_reg >> 1;
                    ym_reg <= ym_reg >> 1;
                end
            end
            ST_SQX: acc_reg <= SQ_W'(mul_reg);
            ST_SQY: acc_reg <= acc_reg + SQ_W'(mul_reg);
            ST_SQSUM: begin
                acc_reg  <= acc_reg + SQ_W'(mul_reg);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_ROOT: begin
                rem_reg  <= root_ge ? REM_W'(rem_n - trial) : rem_n;
                root_reg <= {root_reg[ROOT_W-2:0], root_ge};
                acc_reg  <= acc_reg << 2;
            end
            ST_DEN: begin
                den_reg <= DEN_W'({root_reg, 16'b0}) - DEN_W'(root_reg);
                if (root_reg == '0) begin
                    qz_reg <= '0;
                    qy_reg <= '0;
                    qx_reg <= '0;
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    case (ax_reg)
                        AX_Y:    qy_reg <= div_quot[QUOT_W-1:0];
                        AX_X:    qx_reg <= div_quot[QUOT_W-1:0];
                        default: qz_reg <= div_quot[QUOT_W-1:0];
                    endcase
                end
            end
            ST_AWAIT: begin
                // low bits of the signed average, truncated toward zero
                if (div_done) begin
                    avg_reg <= sum_neg ? $signed(VAL_W'(-div_quot)) : $signed(div_quot);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, statistics and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ax_reg        <= AX_Z;
            scnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_PIX;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            last_reg      <= 1'b0;
            sum_z_reg     <= '0;
            sum_y_reg     <= '0;
            sum_x_reg     <= '0;
            lo_z_reg      <= Z_MIN_START;
            hi_z_reg      <= '0;
            lo_y_reg      <= '0;
            hi_y_reg      <= '0;
            lo_x_reg      <= '0;
            hi_x_reg      <= '0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        state_reg <= ST_DNUM;
                    end
                end
                ST_DNUM:  state_reg <= ST_XM;
                ST_XM:    state_reg <= ST_YM;
                ST_YM:    state_reg <= ST_LDY;
                ST_LDY:   state_reg <= ST_NORM;
                ST_NORM: begin
                    if (!norm_more) begin
                        state_reg <= ST_SQF;
                    end
                end
                ST_SQF:   state_reg <= ST_SQX;
                ST_SQX:   state_reg <= ST_SQY;
                ST_SQY:   state_reg <= ST_SQSUM;
                ST_SQSUM: begin
                    scnt_reg  <= SCNT_W'(ROOT_W - 1);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    scnt_reg <= scnt_reg - SCNT_W'(1);
                    if (scnt_reg == '0) begin
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    ax_reg    <= AX_Z;
                    state_reg <= (root_reg == '0) ? ST_PIX : ST_NUM;
                end
                ST_NUM:    state_reg <= ST_DSTART;
                ST_DSTART: state_reg <= ST_DWAIT;
                ST_DWAIT: begin
                    if (div_done) begin
                        if (ax_reg == AX_X) begin
                            state_reg <= ST_PIX;
                        end else begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= ST_NUM;
                        end
                    end
                end
                ST_PIX: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_PIX;
                        a_reg         <= z_pix;
                        b_reg         <= y_pix;
                        c_reg         <= x_pix;
                        last_reg      <= !req_reg.frame_end;
                        sum_z_reg     <= sum_z_reg + SUM_W'(z_pix);
                        sum_y_reg     <= sum_y_reg + SUM_W'(y_pix);
                        sum_x_reg     <= sum_x_reg + SUM_W'(x_pix);
                        if (z_pix < lo_z_reg) lo_z_reg <= z_pix;
                        if (z_pix > hi_z_reg) hi_z_reg <= z_pix;
                        if (y_pix < lo_y_reg) lo_y_reg <= y_pix;
                        if (y_pix > hi_y_reg) hi_y_reg <= y_pix;
                        if (x_pix < lo_x_reg) lo_x_reg <= x_pix;
                        if (x_pix > hi_x_reg) hi_x_reg <= x_pix;
                        ax_reg    <= AX_Z;
                        state_reg <= req_reg.frame_end ? ST_ASTART : ST_IDLE;
                    end
                end
                ST_ASTART: state_reg <= ST_AWAIT;
                ST_AWAIT: begin
                    if (div_done) begin
                        state_reg <= ST_AEMIT;
                    end
                end
                ST_AEMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= stat_kind;
                        a_reg         <= avg_reg;
                        b_reg         <= lo_sel;
                        c_reg         <= hi_sel;
                        last_reg      <= (ax_reg == AX_X);
                        if (ax_reg == AX_X) begin
                            sum_z_reg <= '0;
                            sum_y_reg <= '0;
                            sum_x_reg <= '0;
                            lo_z_reg  <= Z_MIN_START;
                            hi_z_reg  <= '0;
                            lo_y_reg  <= '0;
                            hi_y_reg  <= '0;
                            lo_x_reg  <= '0;
                            hi_x_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= ST_ASTART;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/tof_phase_to_xyz_with_stats_core.sv -----
// Top level: ToF phase to XYZ converter with per-frame statistics.
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    s_phase
//  m_       out  m_valid / m_ready    m_item_kind, m_value_a/b/c, m_last_of_run
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A pixel in the back end takes up to 14 normalize shifts,
//  27 square-root steps and three 16-step divides through one shared divider.
//  A zero-length ray skips the divides.
//  A frame end adds three 58-step divides for the averages.
//  The front end queues up to two pixel requests, so input stalls only when it fills.
//  Reset (aresetn low, synchronous) restores register defaults, counters and stats.
//  The output register holds an item until m_ready; the back end waits only when its next item is ready.
module tof_phase_to_xyz_with_stats_core #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpx_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tpx_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [15:0]                          s_phase,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_item_kind,
    output logic signed [tpx_pkg::VAL_W-1:0]     m_value_a,
    output logic signed [tpx_pkg::VAL_W-1:0]     m_value_b,
    output logic signed [tpx_pkg::VAL_W-1:0]     m_value_c,
    output logic                                 m_last_of_run
);
    import tpx_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push, q_full, q_pop, q_valid;
    pix_req_t q_in, q_out;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_cols   <= 11'd176;
            cfg_reg.frame_rows   <= 11'd144;
            cfg_reg.centre_col   <= 14'd1408;
            cfg_reg.centre_row   <= 14'd1152;
            cfg_reg.pitch_col    <= 24'd2621;
            cfg_reg.pitch_row    <= 24'd2621;
            cfg_reg.focal_len    <= 24'd524288;
            cfg_reg.max_range_mm <= 16'd7500;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                IDX_FRAME_COLS: cfg_reg.frame_cols   <= cfg_data[10:0];
                IDX_FRAME_ROWS: cfg_reg.frame_rows   <= cfg_data[10:0];
                IDX_CENTRE_COL: cfg_reg.centre_col   <= cfg_data[13:0];
                IDX_CENTRE_ROW: cfg_reg.centre_row   <= cfg_data[13:0];
                IDX_PITCH_COL:  cfg_reg.pitch_col    <= cfg_data;
                IDX_PITCH_ROW:  cfg_reg.pitch_row    <= cfg_data;
                IDX_FOCAL_LEN:  cfg_reg.focal_len    <= cfg_data;
                IDX_MAX_RANGE:  cfg_reg.max_range_mm <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    tpx_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_phase (s_phase),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    tpx_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_valid)
    );

    tpx_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .req_valid     (q_valid),
        .req_data      (q_out),
        .req_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_value_a     (m_value_a),
        .m_value_b     (m_value_b),
        .m_value_c     (m_value_c),
        .m_last_of_run (m_last_of_run)
    );

    // Pixel depth is never negative
    a_pix_z_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_PIX) |-> !m_value_a[VAL_W-1])
        else $error("pixel z negative");

    // The x statistics request closes a frame
    a_x_stats_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_X) |-> m_last_of_run)
        else $error("x stats without last flag");

    // z and y statistics never close a run
    a_zy_stats_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_item_kind == KIND_Z) || (m_item_kind == KIND_Y)) |-> !m_last_of_run)
        else $error("z or y stats flagged last");

    // Queue pop only when something is queued
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule
